/* rtl/swfe_pkg.sv */
package swfe_pkg;

  // number of frame types, each with its own sequence counter
  localparam int NumTypes = 4;
  localparam int TypeIdxW = $clog2(NumTypes);

  // depth of the command queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // input modes
  localparam logic [1:0] ModeStart   = 2'd0;
  localparam logic [1:0] ModePayload = 2'd1;
  localparam logic [1:0] ModeClear   = 2'd2;

  // sync word bytes
  localparam logic [7:0] Sync0 = 8'hA5;
  localparam logic [7:0] Sync1 = 8'h5A;
  localparam logic [7:0] Sync2 = 8'hE1;
  localparam logic [7:0] Sync3 = 8'h1E;

  // byte steps of the back end sequencer
  localparam int         StepW       = 4;
  localparam logic [3:0] StepFirst   = 4'd0;
  localparam logic [3:0] StepHdrLast = 4'd11;
  localparam logic [3:0] StepSumLo   = 4'd12;
  localparam logic [3:0] StepSumHi   = 4'd13;

  typedef enum logic [1:0] {
    KindHeader,
    KindPayload,
    KindReject
  } cmd_kind_e;

  // one classified command from front to back
  typedef struct packed {
    cmd_kind_e   kind;
    logic [1:0]  frame_type;
    logic [15:0] seq;
    logic [15:0] aux;
    logic [15:0] len;
    logic [7:0]  data;
    logic [15:0] sum;
    logic        close;
  } cmd_t;

  // queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

/* rtl/swfe_front.sv */
module swfe_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [1:0]           frame_type_i,
  input  logic [15:0]          aux_word_i,
  input  logic [15:0]          frame_length_i,
  input  logic [7:0]           payload_byte_i,
  input  swfe_pkg::q_stat_t    q_stat_i,
  output logic                 push_o,
  output swfe_pkg::cmd_t       cmd_o
);

  logic [15:0] seq_q [swfe_pkg::NumTypes];
  logic [15:0] seq_d [swfe_pkg::NumTypes];
  logic [15:0] sum_q, sum_d;
  logic [15:0] left_q, left_d;
  logic        open_q, open_d;

  logic                          accept;
  logic                          type_ok;
  logic [swfe_pkg::TypeIdxW-1:0] type_idx;
  logic [15:0]                   cur_seq;
  logic [15:0]                   hdr_sum;
  logic [15:0]                   pay_sum;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign type_ok    = 32'(frame_type_i) < swfe_pkg::NumTypes;
  assign type_idx   = swfe_pkg::TypeIdxW'(frame_type_i);
  assign cur_seq    = seq_q[type_idx];

  // header checksum over bytes from offset four on
  assign hdr_sum = 16'(frame_type_i) + 16'(cur_seq[7:0]) + 16'(cur_seq[15:8])
                 + 16'(aux_word_i[7:0]) + 16'(aux_word_i[15:8])
                 + 16'(frame_length_i[7:0]) + 16'(frame_length_i[15:8]);
  assign pay_sum = sum_q + 16'(payload_byte_i);

  // classify the item and update frame state
  always_comb begin
    seq_d  = seq_q;
    sum_d  = sum_q;
    left_d = left_q;
    open_d = open_q;
    push_o = 1'b0;
    cmd_o            = '0;
    cmd_o.kind       = swfe_pkg::KindReject;
    cmd_o.frame_type = frame_type_i;
    cmd_o.seq        = cur_seq;
    cmd_o.aux        = aux_word_i;
    cmd_o.len        = frame_length_i;
    cmd_o.data       = payload_byte_i;
    if (accept) begin
      case (mode_i)
        swfe_pkg::ModeStart: begin
          push_o = 1'b1;
          if (!open_q && type_ok) begin
            cmd_o.kind       = swfe_pkg::KindHeader;
            cmd_o.sum        = hdr_sum;
            cmd_o.close      = (frame_length_i == 16'd0);
            seq_d[type_idx]  = cur_seq + 16'd1;
            sum_d            = hdr_sum;
            open_d           = (frame_length_i != 16'd0);
            left_d           = frame_length_i;
          end
        end
        swfe_pkg::ModePayload: begin
          push_o = 1'b1;
          if (open_q) begin
            cmd_o.kind  = swfe_pkg::KindPayload;
            cmd_o.sum   = pay_sum;
            cmd_o.close = (left_q == 16'd1);
            sum_d       = pay_sum;
            left_d      = left_q - 16'd1;
            if (left_q == 16'd1) begin
              open_d = 1'b0;
            end
          end
        end
        swfe_pkg::ModeClear: begin
          if (type_ok) begin
            seq_d[type_idx] = 16'd0;
          end else begin
            push_o = 1'b1;
          end
        end
        default: begin
          push_o = 1'b1;
        end
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < swfe_pkg::NumTypes; i++) begin
        seq_q[i] <= '0;
      end
      sum_q  <= '0;
      left_q <= '0;
      open_q <= 1'b0;
    end else begin
      seq_q  <= seq_d;
      sum_q  <= sum_d;
      left_q <= left_d;
      open_q <= open_d;
    end
  end

endmodule

/* rtl/swfe_queue.sv */
module swfe_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  swfe_pkg::cmd_t     cmd_i,
  input  logic               pop_i,
  output swfe_pkg::cmd_t     head_o,
  output swfe_pkg::q_stat_t  stat_o
);

  swfe_pkg::cmd_t               mem_q [swfe_pkg::QueueDepth];
  logic [swfe_pkg::QPtrW-1:0]   wr_q, rd_q;
  logic [swfe_pkg::QCntW-1:0]   cnt_q;

  assign head_o       = mem_q[rd_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == swfe_pkg::QCntW'(swfe_pkg::QueueDepth));

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == swfe_pkg::QPtrW'(swfe_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == swfe_pkg::QPtrW'(swfe_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/swfe_back.sv */
module swfe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swfe_pkg::cmd_t     head_i,
  input  swfe_pkg::q_stat_t  q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               end_of_run_o,
  output logic               end_of_frame_o,
  output logic               rejected_o
);

  logic [swfe_pkg::StepW-1:0] step_q, step_d;
  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic       eor_q, eor_d;
  logic       eof_q, eof_d;
  logic       rej_q, rej_d;
  logic       load;
  logic       emit;
  logic [7:0] hdr_byte;

  assign load = !valid_q || out_ready_i;
  assign emit = !q_stat_i.empty && load;

  // header byte at the current step
  always_comb begin
    case (step_q)
      4'd0:    hdr_byte = swfe_pkg::Sync0;
      4'd1:    hdr_byte = swfe_pkg::Sync1;
      4'd2:    hdr_byte = swfe_pkg::Sync2;
      4'd3:    hdr_byte = swfe_pkg::Sync3;
      4'd4:    hdr_byte = 8'(head_i.frame_type);
      4'd5:    hdr_byte = 8'd0;
      4'd6:    hdr_byte = head_i.seq[7:0];
      4'd7:    hdr_byte = head_i.seq[15:8];
      4'd8:    hdr_byte = head_i.aux[7:0];
      4'd9:    hdr_byte = head_i.aux[15:8];
      4'd10:   hdr_byte = head_i.len[7:0];
      4'd11:   hdr_byte = head_i.len[15:8];
      default: hdr_byte = 8'd0;
    endcase
  end

  // expand the head command into bytes
  always_comb begin
    step_d = step_q;
    pop_o  = 1'b0;
    eof_d  = 1'b0;
    rej_d  = 1'b0;
    eor_d  = 1'b0;
    byte_d = 8'd0;
    if (step_q == swfe_pkg::StepSumLo) begin
      byte_d = head_i.sum[7:0];
    end else if (step_q == swfe_pkg::StepSumHi) begin
      byte_d = head_i.sum[15:8];
      eof_d  = 1'b1;
      eor_d  = 1'b1;
    end else begin
      case (head_i.kind)
        swfe_pkg::KindHeader: begin
          byte_d = hdr_byte;
          eor_d  = (step_q == swfe_pkg::StepHdrLast) && !head_i.close;
        end
        swfe_pkg::KindPayload: begin
          byte_d = head_i.data;
          eor_d  = !head_i.close;
        end
        default: begin
          rej_d = 1'b1;
          eor_d = 1'b1;
        end
      endcase
    end
    if (emit) begin
      if (eor_d) begin
        pop_o  = 1'b1;
        step_d = swfe_pkg::StepFirst;
      end else if (head_i.kind == swfe_pkg::KindPayload) begin
        step_d = (step_q == swfe_pkg::StepFirst) ? swfe_pkg::StepSumLo : step_q + 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  // step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= swfe_pkg::StepFirst;
      valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        valid_q <= emit;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      eor_q  <= eor_d;
      eof_q  <= eof_d;
      rej_q  <= rej_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign end_of_run_o   = eor_q;
  assign end_of_frame_o = eof_q;
  assign rejected_o     = rej_q;

endmodule

/* rtl/sync_word_frame_encoder.sv */
// Frame encoder with sync word and 16-bit additive checksum. Each accepted item
// is classified by a front stage, which keeps the per-type sequence counters
// and the open-frame state, and every item but a clear is queued (two entries)
// for a back stage that puts out one byte per cycle, while the output is ready
// and the queue is not empty, through a registered output. A payload item is
// taken every cycle while the queue has room and gives one byte (three when it
// closes the frame); a start gives 12 header bytes (14 for a zero-length frame),
// and input stalls once the queue fills. A clear gives no transfer. From an empty
// queue, an item's first byte passes the queue entry, then the output register.
module sync_word_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [1:0]  frame_type_i,
  input  logic [15:0] aux_word_i,
  input  logic [15:0] frame_length_i,
  input  logic [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        end_of_run_o,
  output logic        end_of_frame_o,
  output logic        rejected_o
);

  logic              push;
  logic              pop;
  swfe_pkg::cmd_t    cmd;
  swfe_pkg::cmd_t    head;
  swfe_pkg::q_stat_t q_stat;

  // classify items and keep frame state
  swfe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .frame_type_i   (frame_type_i),
    .aux_word_i     (aux_word_i),
    .frame_length_i (frame_length_i),
    .payload_byte_i (payload_byte_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  // command queue
  swfe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // byte sequencer and output register
  swfe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .end_of_run_o   (end_of_run_o),
    .end_of_frame_o (end_of_frame_o),
    .rejected_o     (rejected_o)
  );

endmodule

/* rtl/swfe_checker.sv */
module swfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       end_of_run_o,
  input logic       end_of_frame_o,
  input logic       rejected_o
);

  // a waiting output transfer holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("output dropped or changed while stalled");

  // a reject is a lone zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> end_of_run_o && !end_of_frame_o && out_byte_o == 8'd0)
    else $error("malformed reject");

  // the closing checksum byte ends its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> end_of_run_o && !rejected_o)
    else $error("frame end not at end of run");

  // bytes of one run follow without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !end_of_run_o |=> out_valid_o)
    else $error("gap inside a run");

endmodule

bind sync_word_frame_encoder swfe_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_byte_o     (out_byte_o),
  .end_of_run_o   (end_of_run_o),
  .end_of_frame_o (end_of_frame_o),
  .rejected_o     (rejected_o)
);
